>>> hw/rtl/rpp_pkg.sv
`timescale 1ns / 1ps
// Shared constants, result codes and the job record for the RIP packet parser.
// Used by every module of the parser; depends on nothing.

package rpp_pkg;

   localparam logic [4:0] MAX_ENTRIES = 5'd25;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   localparam logic [3:0] ERR_NONE      = 4'd0;
   localparam logic [3:0] ERR_TRUNCATED = 4'd1;
   localparam logic [3:0] ERR_COMMAND   = 4'd2;
   localparam logic [3:0] ERR_VERSION   = 4'd3;
   localparam logic [3:0] ERR_ZERO      = 4'd4;
   localparam logic [3:0] ERR_FAMILY    = 4'd5;
   localparam logic [3:0] ERR_TAG       = 4'd6;
   localparam logic [3:0] ERR_MASK      = 4'd7;
   localparam logic [3:0] ERR_METRIC    = 4'd8;
   localparam logic [3:0] ERR_TOO_MANY  = 4'd9;

   localparam logic [7:0] CMD_REQUEST  = 8'd1;
   localparam logic [7:0] CMD_RESPONSE = 8'd2;
   localparam logic [7:0] RIP_VERSION  = 8'd2;
   localparam logic [7:0] FAMILY_NONE  = 8'd0;
   localparam logic [7:0] FAMILY_INET  = 8'd2;
   localparam logic [7:0] METRIC_MAX   = 8'd16;

   localparam logic KIND_ENTRY   = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   localparam logic [4:0] ENTRY_FAMILY_HI = 5'd0;
   localparam logic [4:0] ENTRY_FAMILY_LO = 5'd1;
   localparam logic [4:0] ENTRY_TAG_HI    = 5'd2;
   localparam logic [4:0] ENTRY_TAG_LO    = 5'd3;
   localparam logic [4:0] ENTRY_DATA      = 5'd4;
   localparam logic [4:0] ENTRY_MASK_LAST = 5'd11;
   localparam logic [4:0] ENTRY_LAST      = 5'd19;

   // Reciprocal of five scaled by 2**16; exact for dividends below 2**14.
   localparam logic [13:0] DIV5_RECIP = 14'd13108;

   typedef struct packed {
      logic        entry_valid;
      logic        verdict_valid;
      logic [4:0]  entry_index;
      logic [31:0] route_addr;
      logic [31:0] route_mask;
      logic [31:0] next_hop;
      logic [31:0] route_metric;
      logic [7:0]  rip_command;
      logic [3:0]  first_error;
      logic        truncated;
      logic [15:0] ip_length;
      logic [3:0]  header_words;
   } rpp_job_type;

endpackage

>>> hw/rtl/rpp_front.sv
`timescale 1ns / 1ps
// Byte parser: walks the IP, UDP and RIP headers and route entries one byte a cycle when
// the queue has room. Produces one job per byte that causes results. Depends on rpp_pkg.

module rpp_front import rpp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_buffer,
   input  logic        queue_full,
   output logic        job_push,
   output rpp_job_type job
);

   logic [15:0] pos_ff, pos_in;
   logic [3:0]  hw_ff, hw_in;
   logic [15:0] total_ff, total_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [4:0]  k_ff, k_in;
   logic [63:0] s0_ff, s0_in;
   logic [63:0] s1_ff, s1_in;
   logic [4:0]  done_ff, done_in;
   logic [3:0]  ferr_ff, ferr_in;

   logic        accept;
   logic [7:0]  b;
   logic [3:0]  hw_cur;
   logic [6:0]  start_pos;
   logic [6:0]  base_pos;
   logic [15:0] start16;
   logic [16:0] entry_end;
   logic        in_region;
   logic [3:0]  step_err;
   logic [3:0]  ferr_next;
   logic [15:0] total_next;
   logic [7:0]  cmd_next;
   logic [63:0] s0_next;
   logic [63:0] s1_next;
   logic [4:0]  k_next;
   logic [4:0]  done_next;
   logic [3:0]  lane;
   logic [31:0] mask_be;
   logic [31:0] mask_inv;
   logic        mask_ok;
   logic        metric_ok;
   logic        entry_emit;
   logic [16:0] received;
   logic        truncated;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign b         = req_data_byte;

   always_comb begin
      hw_cur    = (pos_ff == 16'd0) ? b[3:0] : hw_ff;
      start_pos = {1'b0, hw_cur, 2'b00} + 7'd8;
      base_pos  = start_pos + 7'd4;
      start16   = {9'd0, start_pos};
      entry_end = {1'b0, pos_ff} - {12'd0, k_ff} + 17'd20;
      in_region = (pos_ff >= {9'd0, base_pos}) && (entry_end <= {1'b0, total_ff}) &&
                  (done_ff < MAX_ENTRIES);

      mask_be   = {s0_ff[39:32], s0_ff[47:40], s0_ff[55:48], b};
      mask_inv  = ~mask_be;
      mask_ok   = (mask_inv & (mask_inv + 32'd1)) == 32'd0;
      metric_ok = (s1_ff[55:32] == 24'd0) && (b != 8'd0) && (b <= METRIC_MAX);
      lane      = 4'(k_ff - ENTRY_DATA);

      step_err   = ERR_NONE;
      total_next = total_ff;
      cmd_next   = cmd_ff;
      s0_next    = s0_ff;
      s1_next    = s1_ff;
      k_next     = k_ff;
      done_next  = done_ff;

      if (pos_ff == 16'd2) begin
         total_next = {b, total_ff[7:0]};
      end
      if (pos_ff == 16'd3) begin
         total_next = {total_ff[15:8], b};
      end
      if (pos_ff == start16) begin
         cmd_next = b;
         if (b != CMD_REQUEST && b != CMD_RESPONSE) begin
            step_err = ERR_COMMAND;
         end
      end
      if (pos_ff == start16 + 16'd1) begin
         if (b != RIP_VERSION) begin
            step_err = ERR_VERSION;
         end
      end
      if (pos_ff == start16 + 16'd2 || pos_ff == start16 + 16'd3) begin
         if (b != 8'd0) begin
            step_err = ERR_ZERO;
         end
      end

      if (in_region) begin
         case (k_ff)
            ENTRY_FAMILY_HI: begin
               if (b != 8'd0) begin
                  step_err = ERR_FAMILY;
               end
            end
            ENTRY_FAMILY_LO: begin
               if (cmd_ff == CMD_REQUEST) begin
                  if (b != FAMILY_NONE) begin
                     step_err = ERR_FAMILY;
                  end
               end else if (cmd_ff == CMD_RESPONSE) begin
                  if (b != FAMILY_INET) begin
                     step_err = ERR_FAMILY;
                  end
               end else begin
                  step_err = ERR_FAMILY;
               end
            end
            ENTRY_TAG_HI, ENTRY_TAG_LO: begin
               if (b != 8'd0) begin
                  step_err = ERR_TAG;
               end
            end
            default: begin
               if (lane[3]) begin
                  s1_next[{lane[2:0], 3'b000} +: 8] = b;
               end else begin
                  s0_next[{lane[2:0], 3'b000} +: 8] = b;
               end
               if (k_ff == ENTRY_MASK_LAST && !mask_ok) begin
                  step_err = ERR_MASK;
               end
               if (k_ff == ENTRY_LAST && !metric_ok) begin
                  step_err = ERR_METRIC;
               end
            end
         endcase
         if (k_ff == ENTRY_LAST) begin
            k_next    = 5'd0;
            done_next = done_ff + 5'd1;
         end else begin
            k_next = k_ff + 5'd1;
         end
      end

      ferr_next  = (ferr_ff != ERR_NONE) ? ferr_ff : step_err;
      entry_emit = in_region && (k_ff == ENTRY_LAST) && (ferr_next == ERR_NONE);
      received   = {1'b0, pos_ff} + 17'd1;
      truncated  = ({1'b0, total_next} > received) ||
                   (received < {10'd0, start_pos} + 17'd4);

      job.entry_valid   = entry_emit;
      job.verdict_valid = req_end_of_buffer;
      job.entry_index   = done_ff;
      job.route_addr    = s0_next[31:0];
      job.route_mask    = s0_next[63:32];
      job.next_hop      = s1_next[31:0];
      job.route_metric  = s1_next[63:32];
      job.rip_command   = cmd_next;
      job.first_error   = ferr_next;
      job.truncated     = truncated;
      job.ip_length     = total_next;
      job.header_words  = hw_cur;
      job_push          = accept && (entry_emit || req_end_of_buffer);

      pos_in   = pos_ff;
      hw_in    = hw_ff;
      total_in = total_ff;
      cmd_in   = cmd_ff;
      k_in     = k_ff;
      s0_in    = s0_ff;
      s1_in    = s1_ff;
      done_in  = done_ff;
      ferr_in  = ferr_ff;
      if (accept) begin
         if (req_end_of_buffer) begin
            pos_in   = '0;
            hw_in    = '0;
            total_in = '0;
            cmd_in   = '0;
            k_in     = '0;
            s0_in    = '0;
            s1_in    = '0;
            done_in  = '0;
            ferr_in  = ERR_NONE;
         end else begin
            pos_in   = (pos_ff != 16'hffff) ? pos_ff + 16'd1 : pos_ff;
            hw_in    = hw_cur;
            total_in = total_next;
            cmd_in   = cmd_next;
            k_in     = k_next;
            s0_in    = s0_next;
            s1_in    = s1_next;
            done_in  = done_next;
            ferr_in  = ferr_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         hw_ff    <= '0;
         total_ff <= '0;
         cmd_ff   <= '0;
         k_ff     <= '0;
         s0_ff    <= '0;
         s1_ff    <= '0;
         done_ff  <= '0;
         ferr_ff  <= ERR_NONE;
      end else begin
         pos_ff   <= pos_in;
         hw_ff    <= hw_in;
         total_ff <= total_in;
         cmd_ff   <= cmd_in;
         k_ff     <= k_in;
         s0_ff    <= s0_in;
         s1_ff    <= s1_in;
         done_ff  <= done_in;
         ferr_ff  <= ferr_in;
      end
   end

endmodule

>>> hw/rtl/rpp_queue.sv
`timescale 1ns / 1ps
// Short first-in first-out queue of parser jobs between the byte parser and the result stage.
// Depends on rpp_pkg.

module rpp_queue import rpp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  rpp_job_type push_job,
   output logic        full,
   input  logic        pop,
   output rpp_job_type pop_job,
   output logic        empty
);

   rpp_job_type               data_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]         count_ff, count_in;

   assign full    = count_ff == (QUEUE_AW + 1)'(QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign pop_job = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push || pop)
      else $error("job queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("job queue read while empty");
`endif

endmodule

>>> hw/rtl/rpp_back.sv
`timescale 1ns / 1ps
// Result stage: derives the entry count from the total length and header size,
// then sends the entry and verdict words of each job. Depends on rpp_pkg.

module rpp_back import rpp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        queue_empty,
   input  rpp_job_type queue_job,
   output logic        queue_pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_result_kind,
   output logic [4:0]  rsp_entry_index,
   output logic [31:0] rsp_route_addr,
   output logic [31:0] rsp_route_mask,
   output logic [31:0] rsp_next_hop,
   output logic [31:0] rsp_route_metric,
   output logic [7:0]  rsp_rip_command,
   output logic        rsp_packet_ok,
   output logic [3:0]  rsp_error_code,
   output logic [4:0]  rsp_entry_total,
   output logic        rsp_last_of_run
);

   logic        s1_valid_ff, s1_valid_in;
   rpp_job_type s1_job_ff, s1_job_in;
   logic [13:0] s1_quot4_ff, s1_quot4_in;
   logic        s1_short_ff, s1_short_in;

   logic        s2_valid_ff, s2_valid_in;
   rpp_job_type s2_job_ff, s2_job_in;
   logic [11:0] s2_cnt_ff, s2_cnt_in;
   logic        s2_sent_ff, s2_sent_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        kind_ff, kind_in;
   logic [4:0]  index_ff, index_in;
   logic [31:0] addr_ff, addr_in;
   logic [31:0] mask_ff, mask_in;
   logic [31:0] hop_ff, hop_in;
   logic [31:0] metric_ff, metric_in;
   logic [7:0]  command_ff, command_in;
   logic        ok_ff, ok_in;
   logic [3:0]  error_ff, error_in;
   logic [4:0]  total_ff, total_in;
   logic        last_ff, last_in;

   logic [6:0]  base_len;
   logic [16:0] body_len;
   logic [27:0] product;
   logic        out_free;
   logic        entry_pending;
   logic        s2_emit;
   logic        s2_done;
   logic        s2_take;
   logic        s1_take;
   logic        too_many;
   logic [4:0]  count_capped;
   logic [3:0]  verdict_err;

   always_comb begin
      out_free      = !rsp_valid_ff || rsp_ready;
      entry_pending = s2_job_ff.entry_valid && !s2_sent_ff;
      s2_emit       = s2_valid_ff && out_free;
      s2_done       = s2_emit && !(entry_pending && s2_job_ff.verdict_valid);
      s2_take       = !s2_valid_ff || s2_done;
      s1_take       = !s1_valid_ff || s2_take;
      queue_pop     = !queue_empty && s1_take;

      base_len    = {1'b0, queue_job.header_words, 2'b00} + 7'd12;
      body_len    = {1'b0, queue_job.ip_length} - {10'd0, base_len};
      s1_valid_in = s1_take ? !queue_empty : s1_valid_ff;
      s1_job_in   = s1_take ? queue_job : s1_job_ff;
      s1_quot4_in = s1_take ? body_len[15:2] : s1_quot4_ff;
      s1_short_in = s1_take ? body_len[16] : s1_short_ff;

      product     = s1_quot4_ff * DIV5_RECIP;
      s2_valid_in = s2_take ? s1_valid_ff : s2_valid_ff;
      s2_job_in   = s2_take ? s1_job_ff : s2_job_ff;
      s2_cnt_in   = s2_take ? (s1_short_ff ? 12'd0 : product[27:16]) : s2_cnt_ff;
      s2_sent_in  = s2_take ? 1'b0 : (s2_emit ? 1'b1 : s2_sent_ff);

      too_many     = s2_cnt_ff > {7'd0, MAX_ENTRIES};
      count_capped = too_many ? MAX_ENTRIES : s2_cnt_ff[4:0];
      if (s2_job_ff.truncated) begin
         verdict_err = ERR_TRUNCATED;
      end else if (s2_job_ff.first_error != ERR_NONE) begin
         verdict_err = s2_job_ff.first_error;
      end else if (too_many) begin
         verdict_err = ERR_TOO_MANY;
      end else begin
         verdict_err = ERR_NONE;
      end

      rsp_valid_in = out_free ? s2_valid_ff : rsp_valid_ff;
      kind_in      = kind_ff;
      index_in     = index_ff;
      addr_in      = addr_ff;
      mask_in      = mask_ff;
      hop_in       = hop_ff;
      metric_in    = metric_ff;
      command_in   = command_ff;
      ok_in        = ok_ff;
      error_in     = error_ff;
      total_in     = total_ff;
      last_in      = last_ff;
      if (s2_emit) begin
         command_in = s2_job_ff.rip_command;
         if (entry_pending) begin
            kind_in   = KIND_ENTRY;
            index_in  = s2_job_ff.entry_index;
            addr_in   = s2_job_ff.route_addr;
            mask_in   = s2_job_ff.route_mask;
            hop_in    = s2_job_ff.next_hop;
            metric_in = s2_job_ff.route_metric;
            ok_in     = 1'b0;
            error_in  = ERR_NONE;
            total_in  = 5'd0;
            last_in   = !s2_job_ff.verdict_valid;
         end else begin
            kind_in   = KIND_VERDICT;
            index_in  = 5'd0;
            addr_in   = 32'd0;
            mask_in   = 32'd0;
            hop_in    = 32'd0;
            metric_in = 32'd0;
            ok_in     = verdict_err == ERR_NONE;
            error_in  = verdict_err;
            total_in  = count_capped;
            last_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s2_sent_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s2_sent_ff   <= s2_sent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_job_ff   <= s1_job_in;
      s1_quot4_ff <= s1_quot4_in;
      s1_short_ff <= s1_short_in;
      s2_job_ff   <= s2_job_in;
      s2_cnt_ff   <= s2_cnt_in;
      kind_ff     <= kind_in;
      index_ff    <= index_in;
      addr_ff     <= addr_in;
      mask_ff     <= mask_in;
      hop_ff      <= hop_in;
      metric_ff   <= metric_in;
      command_ff  <= command_in;
      ok_ff       <= ok_in;
      error_ff    <= error_in;
      total_ff    <= total_in;
      last_ff     <= last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = kind_ff;
   assign rsp_entry_index  = index_ff;
   assign rsp_route_addr   = addr_ff;
   assign rsp_route_mask   = mask_ff;
   assign rsp_next_hop     = hop_ff;
   assign rsp_route_metric = metric_ff;
   assign rsp_rip_command  = command_ff;
   assign rsp_packet_ok    = ok_ff;
   assign rsp_error_code   = error_ff;
   assign rsp_entry_total  = total_ff;
   assign rsp_last_of_run  = last_ff;

`ifndef SYNTHESIS
   a_verdict_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_VERDICT |-> rsp_last_of_run)
      else $error("verdict word without last mark");

   a_verdict_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_VERDICT |->
      rsp_packet_ok == (rsp_error_code == ERR_NONE))
      else $error("verdict status disagrees with error code");

   a_entry_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_ENTRY |->
      !rsp_packet_ok && rsp_error_code == ERR_NONE && rsp_entry_index < MAX_ENTRIES)
      else $error("entry word carries verdict fields or bad index");
`endif

endmodule

>>> hw/rtl/rip_packet_parser_core.sv
`timescale 1ns / 1ps
// Top level of the RIPv2 packet parser: byte parser, job queue and result stage.
// Depends on rpp_pkg, rpp_front, rpp_queue and rpp_back.

// The parser takes one datagram byte per cycle on the req_ channel with no gaps required,
// and sends one word per route entry that passes every check, followed by a verdict word
// on the final byte of the buffer. Each byte is parsed in the cycle it is accepted; bytes
// that produce words place a job into a four-deep queue, and the result stage moves it
// through its s1, s2 and output registers to the rsp_ outputs; the multiply from length
// to entry count lies between s1 and s2. A final byte that closes an entry yields two
// words and holds s2 until both are sent. Input stalls only when the queue is full.

module rip_packet_parser_core import rpp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_buffer,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_result_kind,
   output logic [4:0]  rsp_entry_index,
   output logic [31:0] rsp_route_addr,
   output logic [31:0] rsp_route_mask,
   output logic [31:0] rsp_next_hop,
   output logic [31:0] rsp_route_metric,
   output logic [7:0]  rsp_rip_command,
   output logic        rsp_packet_ok,
   output logic [3:0]  rsp_error_code,
   output logic [4:0]  rsp_entry_total,
   output logic        rsp_last_of_run
);

   logic        job_push;
   rpp_job_type push_job;
   logic        queue_full;
   logic        queue_pop;
   logic        queue_empty;
   rpp_job_type pop_job;

   rpp_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_end_of_buffer (req_end_of_buffer),
      .queue_full        (queue_full),
      .job_push          (job_push),
      .job               (push_job)
   );

   rpp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (queue_pop),
      .pop_job  (pop_job),
      .empty    (queue_empty)
   );

   rpp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .queue_empty      (queue_empty),
      .queue_job        (pop_job),
      .queue_pop        (queue_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_entry_index  (rsp_entry_index),
      .rsp_route_addr   (rsp_route_addr),
      .rsp_route_mask   (rsp_route_mask),
      .rsp_next_hop     (rsp_next_hop),
      .rsp_route_metric (rsp_route_metric),
      .rsp_rip_command  (rsp_rip_command),
      .rsp_packet_ok    (rsp_packet_ok),
      .rsp_error_code   (rsp_error_code),
      .rsp_entry_total  (rsp_entry_total),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule

>>> dv/rip_packet_parser_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for rip_packet_parser_core: feeds whole and damaged datagrams
// byte by byte and checks every route and verdict word against a built-in parser model.
// Depends on rpp_pkg and the parser RTL.

module rip_packet_parser_core_tb;
   import rpp_pkg::*;

   localparam int ITEM_TARGET = 1850;
   localparam int STALL_LIMIT = 1000;

   typedef struct packed {
      logic        kind;
      logic [4:0]  index;
      logic [31:0] addr;
      logic [31:0] mask;
      logic [31:0] hop;
      logic [31:0] metric;
      logic [7:0]  command;
      logic        ok;
      logic [3:0]  err;
      logic [4:0]  total;
      logic        last;
   } rip_word_type;

   class rip_book_type;
      logic [15:0]  position;
      logic [3:0]   ihl;
      logic [15:0]  total_len;
      logic [7:0]   command;
      logic [4:0]   offset;
      logic [63:0]  shift [2];
      logic [4:0]   done;
      logic [3:0]   first_err;
      rip_word_type pending[$];
      int           failures;

      function new();
         failures = 0;
         clear();
      endfunction

      function void clear();
         position  = '0;
         ihl       = '0;
         total_len = '0;
         command   = '0;
         offset    = '0;
         shift[0]  = '0;
         shift[1]  = '0;
         done      = '0;
         first_err = ERR_NONE;
      endfunction

      function void flag_error(logic [3:0] code);
         if (first_err == ERR_NONE) begin
            first_err = code;
         end
      endfunction

      function logic [31:0] byte_swap(logic [31:0] m);
         return {m[7:0], m[15:8], m[23:16], m[31:24]};
      endfunction

      function bit contiguous(logic [31:0] m);
         logic [31:0] inv;
         inv = ~byte_swap(m);
         return (inv & (inv + 32'd1)) == 32'd0;
      endfunction

      function int unsigned route_count();
         int unsigned base;
         base = ihl * 4 + 12;
         if (total_len < base) begin
            return 0;
         end
         return (total_len - base) / 20;
      endfunction

      function int outstanding();
         return pending.size();
      endfunction

      function void take_byte(logic [7:0] b, logic eob);
         int unsigned  pos;
         int unsigned  start;
         int unsigned  cnt;
         int unsigned  r;
         logic [4:0]   k;
         logic [3:0]   err;
         logic [31:0]  met;
         rip_word_type w;
         rip_word_type out_words[$];
         pos = position;
         start = ihl * 4 + 8;
         if (pos == 0) begin
            ihl = b[3:0];
            start = ihl * 4 + 8;
         end else if (pos == 2) begin
            total_len[15:8] = b;
         end else if (pos == 3) begin
            total_len[7:0] = b;
         end else if (pos == start) begin
            command = b;
            if (b != CMD_REQUEST && b != CMD_RESPONSE) flag_error(ERR_COMMAND);
         end else if (pos == start + 1) begin
            if (b != RIP_VERSION) flag_error(ERR_VERSION);
         end else if (pos == start + 2 || pos == start + 3) begin
            if (b != 8'h00) flag_error(ERR_ZERO);
         end else if (pos >= start + 4 && pos < start + 4 + 20 * route_count() &&
                      done < MAX_ENTRIES) begin
            k = offset;
            if (k == ENTRY_FAMILY_HI) begin
               if (b != FAMILY_NONE) flag_error(ERR_FAMILY);
            end else if (k == ENTRY_FAMILY_LO) begin
               if (command == CMD_REQUEST) begin
                  if (b != FAMILY_NONE) flag_error(ERR_FAMILY);
               end else if (command == CMD_RESPONSE) begin
                  if (b != FAMILY_INET) flag_error(ERR_FAMILY);
               end else begin
                  flag_error(ERR_FAMILY);
               end
            end else if (k == ENTRY_TAG_HI || k == ENTRY_TAG_LO) begin
               if (b != 8'h00) flag_error(ERR_TAG);
            end else begin
               r = k - ENTRY_DATA;
               shift[r / 8][(r % 8) * 8 +: 8] = b;
               if (k == ENTRY_MASK_LAST && !contiguous(shift[0][63:32])) begin
                  flag_error(ERR_MASK);
               end
            end
            if (k >= ENTRY_LAST) begin
               met = byte_swap(shift[1][63:32]);
               if (met == 32'd0 || met > METRIC_MAX) flag_error(ERR_METRIC);
               if (first_err == ERR_NONE) begin
                  w = '0;
                  w.kind    = KIND_ENTRY;
                  w.index   = done;
                  w.addr    = shift[0][31:0];
                  w.mask    = shift[0][63:32];
                  w.hop     = shift[1][31:0];
                  w.metric  = shift[1][63:32];
                  w.command = command;
                  out_words.push_back(w);
               end
               done = done + 5'd1;
               offset = '0;
            end else begin
               offset = k + 5'd1;
            end
         end

         if (eob) begin
            cnt = route_count();
            if (total_len > pos + 1 || pos + 1 < start + 4) begin
               err = ERR_TRUNCATED;
            end else if (first_err != ERR_NONE) begin
               err = first_err;
            end else if (cnt > MAX_ENTRIES) begin
               err = ERR_TOO_MANY;
            end else begin
               err = ERR_NONE;
            end
            w = '0;
            w.kind    = KIND_VERDICT;
            w.command = command;
            w.ok      = (err == ERR_NONE);
            w.err     = err;
            w.total   = (cnt > MAX_ENTRIES) ? MAX_ENTRIES : 5'(cnt);
            out_words.push_back(w);
            clear();
         end else if (position != 16'hFFFF) begin
            position = position + 16'd1;
         end

         if (out_words.size() > 0) begin
            out_words[out_words.size() - 1].last = 1'b1;
         end
         foreach (out_words[i]) pending.push_back(out_words[i]);
      endfunction

      function void check_field(string name, logic [31:0] want, logic [31:0] seen);
         if (want !== seen) begin
            failures++;
            if (failures <= 50) begin
               $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, seen);
            end
         end
      endfunction

      function void match_word(rip_word_type seen);
         rip_word_type want;
         if (pending.size() == 0) begin
            failures++;
            if (failures <= 50) begin
               $display("%0t: unexpected word, expected none, got 0x%0h", $time, seen);
            end
            return;
         end
         want = pending.pop_front();
         check_field("result_kind", want.kind, seen.kind);
         check_field("entry_index", want.index, seen.index);
         check_field("route_addr", want.addr, seen.addr);
         check_field("route_mask", want.mask, seen.mask);
         check_field("next_hop", want.hop, seen.hop);
         check_field("route_metric", want.metric, seen.metric);
         check_field("rip_command", want.command, seen.command);
         check_field("packet_ok", want.ok, seen.ok);
         check_field("error_code", want.err, seen.err);
         check_field("entry_total", want.total, seen.total);
         check_field("last_of_run", want.last, seen.last);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_end_of_buffer = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_result_kind;
   logic [4:0]  rsp_entry_index;
   logic [31:0] rsp_route_addr;
   logic [31:0] rsp_route_mask;
   logic [31:0] rsp_next_hop;
   logic [31:0] rsp_route_metric;
   logic [7:0]  rsp_rip_command;
   logic        rsp_packet_ok;
   logic [3:0]  rsp_error_code;
   logic [4:0]  rsp_entry_total;
   logic        rsp_last_of_run;

   rip_book_type book;
   logic [7:0]   frame[$];
   bit           steady = 1'b0;
   int           sent = 0;
   int           frames = 0;
   int           stall_cycles = 0;
   rip_word_type seen;

   rip_packet_parser_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_end_of_buffer (req_end_of_buffer),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_entry_index   (rsp_entry_index),
      .rsp_route_addr    (rsp_route_addr),
      .rsp_route_mask    (rsp_route_mask),
      .rsp_next_hop      (rsp_next_hop),
      .rsp_route_metric  (rsp_route_metric),
      .rsp_rip_command   (rsp_rip_command),
      .rsp_packet_ok     (rsp_packet_ok),
      .rsp_error_code    (rsp_error_code),
      .rsp_entry_total   (rsp_entry_total),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen = {rsp_result_kind, rsp_entry_index, rsp_route_addr, rsp_route_mask,
                 rsp_next_hop, rsp_route_metric, rsp_rip_command, rsp_packet_ok,
                 rsp_error_code, rsp_entry_total, rsp_last_of_run};
         book.match_word(seen);
      end
      rsp_ready <= steady || ($urandom_range(99) >= 38);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function logic [7:0] spoil(logic [7:0] good, bit dirty, int odds);
      if (dirty && $urandom_range(odds - 1) == 0) begin
         return 8'($urandom);
      end
      return good;
   endfunction

   task put_word(input logic [31:0] v);
      frame.push_back(v[31:24]);
      frame.push_back(v[23:16]);
      frame.push_back(v[15:8]);
      frame.push_back(v[7:0]);
   endtask

   task send_byte(input logic [7:0] b, input logic eob);
      while (!steady && $urandom_range(99) < 38) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_end_of_buffer <= eob;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      book.take_byte(b, eob);
      sent++;
   endtask

   task send_frame();
      foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
   endtask

   // A frame is a datagram with a random IP header, a RIP header and route entries.
   // About half the frames are damaged here and there; a few are pure noise.
   task build_frame(input bit clean_big);
      int unsigned ihl;
      int unsigned n;
      int unsigned base;
      int unsigned pfx;
      int          len;
      logic [15:0] total;
      logic [7:0]  cmd;
      logic [31:0] v;
      bit          dirty;
      bit          wild;
      frame.delete();
      if (!clean_big && $urandom_range(99) < 8) begin
         repeat ($urandom_range(1, 48)) frame.push_back(8'($urandom));
         return;
      end
      dirty = !clean_big && ($urandom_range(1) == 1);
      ihl = ($urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(2);
      n = clean_big ? $urandom_range(26, 28) : $urandom_range(3);
      base = ihl * 4 + 12;
      total = 16'(base + 20 * n);
      if ($urandom_range(3) == 0) total = total + 16'($urandom_range(1, 19));
      wild = dirty && $urandom_range(11) == 0;
      if (wild) begin
         total = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(base - 1));
      end

      frame.push_back({4'($urandom), 4'(ihl)});
      frame.push_back(8'($urandom));
      frame.push_back(total[15:8]);
      frame.push_back(total[7:0]);
      repeat (ihl * 4 + 4) frame.push_back(8'($urandom));

      if (dirty && $urandom_range(9) == 0) begin
         cmd = 8'($urandom);
      end else begin
         cmd = $urandom_range(1) ? CMD_RESPONSE : CMD_REQUEST;
      end
      frame.push_back(cmd);
      frame.push_back(spoil(RIP_VERSION, dirty, 20));
      repeat (2) frame.push_back(spoil(8'h00, dirty, 20));

      repeat (n) begin
         frame.push_back(spoil(FAMILY_NONE, dirty, 40));
         frame.push_back(spoil((cmd == CMD_REQUEST) ? FAMILY_NONE : FAMILY_INET, dirty, 40));
         repeat (2) frame.push_back(spoil(8'h00, dirty, 40));
         put_word($urandom);
         pfx = $urandom_range(32);
         v = 32'(64'hFFFF_FFFF_0000_0000 >> pfx);
         if (dirty && $urandom_range(14) == 0) v = $urandom;
         put_word(v);
         put_word($urandom);
         v = $urandom_range(1, 16);
         if (dirty && $urandom_range(14) == 0) begin
            v = $urandom_range(1) ? $urandom : 32'(17 * $urandom_range(1));
         end
         put_word(v);
      end

      if (!wild) begin
         while (frame.size() < total) frame.push_back(8'($urandom));
      end
      if (dirty && $urandom_range(5) == 0) begin
         len = $urandom_range(1, frame.size());
         while (frame.size() > len) void'(frame.pop_back());
      end else if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(1, 20)) frame.push_back(8'($urandom));
      end
   endtask

   initial begin
      book = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // A lone byte, a bare valid header with no entries, and a header with every
      // field wrong under a length that is too short for any entry.
      frame = '{8'hFF};
      send_frame();
      frame = '{8'h40, 8'h00, 8'h00, 8'h0C, 8'h00, 8'h00, 8'h00, 8'h00,
                CMD_REQUEST, RIP_VERSION, 8'h00, 8'h00};
      send_frame();
      frame = '{8'h00, 8'hFF, 8'h00, 8'h00, 8'h5A, 8'hA5, 8'h00, 8'hFF,
                8'hFF, 8'h00, 8'hFF, 8'hFF};
      send_frame();

      while (sent < ITEM_TARGET) begin
         steady = (frames >= 12 && frames < 18);
         build_frame(frames == 4);
         send_frame();
         frames++;
      end
      steady = 1'b0;
      req_valid <= 1'b0;

      while (book.outstanding() > 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (book.failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
